### hdl/frame_presentation_reorder_defines.svh
// assertion macros for the frame presentation reorder block
`ifndef FRAME_PRESENTATION_REORDER_DEFINES_SVH
`define FRAME_PRESENTATION_REORDER_DEFINES_SVH

// same-cycle implication
`define REO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("reorder check failed");

// next-cycle implication
`define REO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("reorder check failed");

`endif

### hdl/reo_pkg.sv
// shared types and constants for the frame presentation reorder block
package reo_pkg;
   localparam int STORE_DEPTH = 16;
   localparam int MAX_OUT = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int FILL_W = $clog2(STORE_DEPTH + 1);
   localparam int OUTCNT_W = $clog2(MAX_OUT + 1);
   localparam int SURF_W = 16;
   localparam int RAW_W = 17;
   localparam int CNT_W = 16;
   localparam int TIME_W = 64;
   localparam int PERIOD_W = 30;
   localparam int PROD_W = PERIOD_W + CNT_W;

   localparam logic STATUS_SHOWN = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   typedef struct packed {
      logic              drop;
      logic [SURF_W-1:0] surface;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic              busy;
      logic [FILL_W-1:0] fill;
   } back_status_type;
endpackage

### hdl/reo_front.sv
// front end: accepts words, halves the count and computes the timestamp
module reo_front import reo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SURF_W-1:0]     req_surface_id,
   input  logic signed [RAW_W-1:0] req_order_count,
   input  logic [TIME_W-1:0]     req_now_time,
   input  logic                  csr_write_enable,
   input  logic [PERIOD_W-1:0]   csr_write_data,
   input  logic                  queue_empty,
   input  back_status_type       back_status,
   output logic                  push_valid,
   output entry_type             push_entry
);
   logic                    s1_ff;
   logic [SURF_W-1:0]       surf_ff;
   logic signed [CNT_W-1:0] cnt_ff;
   logic [TIME_W-1:0]       now_ff;
   logic                    drop_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [PERIOD_W-1:0]     period_ff;
   logic [TIME_W-1:0]       begin_ff;
   logic [TIME_W-1:0]       end_ff;

   logic                    accept;
   logic signed [RAW_W-1:0] halved;
   logic [TIME_W-1:0]       period64;
   logic [TIME_W-1:0]       stamp_in;
   logic [TIME_W-1:0]       begin_in;
   logic [TIME_W-1:0]       end_in;

   assign req_stall = s1_ff || !queue_empty || back_status.busy;
   assign accept = req_valid && !req_stall;
   // truncate toward zero
   assign halved = (req_order_count + RAW_W'(req_order_count[RAW_W-1])) >>> 1;
   assign period64 = TIME_W'(period_ff);

   always_comb begin
      begin_in = begin_ff;
      end_in = end_ff;
      stamp_in = now_ff;
      if (cnt_ff == '0) begin
         begin_in = (end_ff == '0) ? now_ff : end_ff;
         end_in = begin_in + period64;
         stamp_in = begin_in;
      end else if (!cnt_ff[CNT_W-1]) begin
         stamp_in = begin_ff + TIME_W'(prod_ff);
         if (stamp_in >= end_ff) begin
            end_in = stamp_in + period64;
         end
      end
   end

   assign push_valid = s1_ff;
   assign push_entry.drop = drop_ff;
   assign push_entry.surface = surf_ff;
   assign push_entry.count = cnt_ff;
   assign push_entry.stamp = drop_ff ? '0 : stamp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         period_ff <= '0;
         begin_ff <= '0;
         end_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            period_ff <= csr_write_data;
         end
         if (accept) begin
            s1_ff <= 1'b1;
            surf_ff <= req_surface_id;
            cnt_ff <= CNT_W'(halved);
            now_ff <= req_now_time;
            drop_ff <= (back_status.fill == FILL_W'(STORE_DEPTH));
            prod_ff <= PROD_W'(period_ff) * PROD_W'(halved[CNT_W-1:0]);
         end else if (s1_ff) begin
            s1_ff <= 1'b0;
            if (!drop_ff) begin
               begin_ff <= begin_in;
               end_ff <= end_in;
            end
         end
      end
   end
endmodule

### hdl/reo_queue.sv
// short queue between front end and store
module reo_queue import reo_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   entry_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ff;
   logic [PTR_W-1:0]      rd_ff;
   logic [PTR_W:0]        count_ff;

   assign empty = (count_ff == '0);
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            mem_ff[wr_ff] <= push_entry;
            wr_ff <= (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end
endmodule

### hdl/reo_back.sv
// back end: sorted store, insertion walk and release of words
module reo_back import reo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  entry_type         queue_head,
   output logic              queue_pop,
   output back_status_type   status,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SURF_W-1:0] rsp_out_surface,
   output logic [TIME_W-1:0] rsp_show_time,
   output logic              rsp_status,
   output logic              rsp_last
);
   typedef enum logic [1:0] {IDLE, INSERT, RELEASE} state_type;

   state_type           state_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic [IDX_W-1:0]    pos_ff;
   logic [OUTCNT_W-1:0] k_ff;
   logic [CNT_W-1:0]    expect_ff;
   entry_type           new_ff;
   logic [SURF_W-1:0]   surf_ff [STORE_DEPTH];
   logic [CNT_W-1:0]    cnt_ff  [STORE_DEPTH];
   logic [TIME_W-1:0]   time_ff [STORE_DEPTH];
   logic                rsp_valid_ff;
   logic [SURF_W-1:0]   rsp_surf_ff;
   logic [TIME_W-1:0]   rsp_time_ff;
   logic                rsp_status_ff;
   logic                rsp_last_ff;

   logic             out_free;
   logic [IDX_W-1:0] prev_idx;
   logic             do_shift;
   logic             head_elig;
   logic [CNT_W-1:0] expect_in;
   logic             next_elig;
   logic             load_rsp;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign queue_pop = (state_ff == IDLE) && !queue_empty && (!queue_head.drop || out_free);
   assign prev_idx = pos_ff - 1'b1;
   assign do_shift = (pos_ff != '0) && (time_ff[prev_idx] > new_ff.stamp);
   assign head_elig = (fill_ff != '0) && (k_ff != OUTCNT_W'(MAX_OUT))
                      && ((cnt_ff[0] == '0) || (cnt_ff[0] == expect_ff));
   assign expect_in = (cnt_ff[0] == '0) ? CNT_W'(1) : expect_ff + 1'b1;
   assign next_elig = (cnt_ff[1] == '0) || (cnt_ff[1] == expect_in);
   // output register loads a dropped word or a released word
   assign load_rsp = (queue_pop && queue_head.drop)
                     || ((state_ff == RELEASE) && head_elig && out_free);

   assign status.busy = (state_ff != IDLE);
   assign status.fill = fill_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_surface = rsp_surf_ff;
   assign rsp_show_time = rsp_time_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         fill_ff <= '0;
         k_ff <= '0;
         expect_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (queue_pop) begin
                  if (queue_head.drop) begin
                     rsp_surf_ff <= queue_head.surface;
                     rsp_time_ff <= '0;
                     rsp_status_ff <= STATUS_DROPPED;
                     rsp_last_ff <= 1'b1;
                  end else begin
                     new_ff <= queue_head;
                     pos_ff <= fill_ff[IDX_W-1:0];
                     k_ff <= '0;
                     state_ff <= INSERT;
                  end
               end
            end
            INSERT: begin
               if (do_shift) begin
                  surf_ff[pos_ff] <= surf_ff[prev_idx];
                  cnt_ff[pos_ff] <= cnt_ff[prev_idx];
                  time_ff[pos_ff] <= time_ff[prev_idx];
                  pos_ff <= prev_idx;
               end else begin
                  surf_ff[pos_ff] <= new_ff.surface;
                  cnt_ff[pos_ff] <= new_ff.count;
                  time_ff[pos_ff] <= new_ff.stamp;
                  fill_ff <= fill_ff + 1'b1;
                  state_ff <= RELEASE;
               end
            end
            RELEASE: begin
               if (!head_elig) begin
                  state_ff <= IDLE;
               end else if (out_free) begin
                  rsp_surf_ff <= surf_ff[0];
                  rsp_time_ff <= time_ff[0];
                  rsp_status_ff <= STATUS_SHOWN;
                  rsp_last_ff <= (fill_ff == FILL_W'(1)) || !next_elig
                                 || (k_ff == OUTCNT_W'(MAX_OUT - 1));
                  expect_ff <= expect_in;
                  fill_ff <= fill_ff - 1'b1;
                  k_ff <= k_ff + 1'b1;
                  for (int j = 0; j < STORE_DEPTH - 1; j++) begin
                     surf_ff[j] <= surf_ff[j+1];
                     cnt_ff[j] <= cnt_ff[j+1];
                     time_ff[j] <= time_ff[j+1];
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

### hdl/frame_presentation_reorder.sv
// top level of the frame presentation reorder block
//
//  channel | ports        | dir | contents
//  req     | req_*        | in  | surface id, raw order count, current time
//  rsp     | rsp_*        | out | surface, show time, status, last
//  csr     | csr_write_*  | in  | frame period
//
// a word passes the front end register and the queue, then the insertion walk,
// one slot per cycle, and the release loop, one released word per cycle while rsp
// is not stalled (store depth 16); a dropped word skips the walk and goes straight
// to the output register
// synchronous reset clears control state and empties the store, no clearing pass
// a stall on rsp holds the release loop; req stalls until front end, queue and back end are idle
`include "frame_presentation_reorder_defines.svh"

module frame_presentation_reorder import reo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SURF_W-1:0]       req_surface_id,
   input  logic signed [RAW_W-1:0] req_order_count,
   input  logic [TIME_W-1:0]       req_now_time,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SURF_W-1:0]       rsp_out_surface,
   output logic [TIME_W-1:0]       rsp_show_time,
   output logic                    rsp_status,
   output logic                    rsp_last,
   input  logic                    csr_write_enable,
   input  logic [PERIOD_W-1:0]     csr_write_data
);
   logic            push_valid;
   entry_type       push_entry;
   logic            queue_empty;
   logic            queue_pop;
   entry_type       queue_head;
   back_status_type back_status;

   reo_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_surface_id(req_surface_id), .req_order_count(req_order_count),
      .req_now_time(req_now_time),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .queue_empty(queue_empty), .back_status(back_status),
      .push_valid(push_valid), .push_entry(push_entry)
   );

   reo_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push_valid), .push_entry(push_entry),
      .pop(queue_pop), .empty(queue_empty), .head(queue_head)
   );

   reo_back u_back (
      .clock(clock), .reset(reset),
      .queue_empty(queue_empty), .queue_head(queue_head), .queue_pop(queue_pop),
      .status(back_status),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_surface(rsp_out_surface), .rsp_show_time(rsp_show_time),
      .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   `REO_ASSERT_NEXT(a_stall_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `REO_ASSERT_NOW(a_drop_word, clock, reset, rsp_valid && rsp_status == STATUS_DROPPED, rsp_show_time == '0 && rsp_last)
   `REO_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, back_status.fill <= FILL_W'(STORE_DEPTH))
endmodule

### test/testbench.sv
// self-checking testbench for the frame presentation reorder block
`timescale 1ns / 1ps

module testbench;
   import reo_pkg::*;

   localparam int RUN_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      logic [SURF_W-1:0] surface;
      logic [TIME_W-1:0] show_time;
      logic              status;
      logic              last;
   } shown_word_type;

   class reorder_board;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   begin_t;
      logic [TIME_W-1:0]   end_t;
      logic [CNT_W-1:0]    next_count;
      int                  fill;
      logic [SURF_W-1:0]   held_surface[STORE_DEPTH];
      logic [CNT_W-1:0]    held_count[STORE_DEPTH];
      logic [TIME_W-1:0]   held_time[STORE_DEPTH];
      shown_word_type      shown_q[$];
      int                  errors;

      function new();
         period = 0;
         begin_t = 0;
         end_t = 0;
         next_count = 0;
         fill = 0;
         errors = 0;
      endfunction

      function void push_word(logic [SURF_W-1:0] s, logic [TIME_W-1:0] t, logic st);
         shown_word_type w;
         w.surface = s;
         w.show_time = t;
         w.status = st;
         w.last = 1'b0;
         shown_q.push_back(w);
      endfunction

      function void note_frame(logic [SURF_W-1:0] surf, logic [RAW_W-1:0] raw,
                               logic [TIME_W-1:0] now);
         int oc;
         int cnt;
         logic [CNT_W-1:0] cnt16;
         logic [TIME_W-1:0] t;
         int pos;
         int k;
         shown_word_type w;
         oc = raw[RAW_W-1] ? int'(raw) - (1 << RAW_W) : int'(raw);
         cnt = oc / 2;
         cnt16 = cnt[CNT_W-1:0];
         if (fill >= STORE_DEPTH) begin
            push_word(surf, '0, STATUS_DROPPED);
            w = shown_q.pop_back();
            w.last = 1'b1;
            shown_q.push_back(w);
            return;
         end
         if (cnt == 0) begin
            begin_t = (end_t == 0) ? now : end_t;
            end_t = begin_t + TIME_W'(period);
            t = begin_t;
         end else if (cnt > 0) begin
            t = begin_t + TIME_W'(period) * TIME_W'(cnt);
            if (t >= end_t) end_t = t + TIME_W'(period);
         end else begin
            t = now;
         end
         pos = 0;
         while (pos < fill && held_time[pos] <= t) pos++;
         for (int i = fill; i > pos; i--) begin
            held_surface[i] = held_surface[i-1];
            held_count[i] = held_count[i-1];
            held_time[i] = held_time[i-1];
         end
         held_surface[pos] = surf;
         held_count[pos] = cnt16;
         held_time[pos] = t;
         fill++;
         k = 0;
         while (k < MAX_OUT && fill > 0 &&
                (held_count[0] == 0 || held_count[0] == next_count)) begin
            push_word(held_surface[0], held_time[0], STATUS_SHOWN);
            k++;
            if (held_count[0] == 0) next_count = 1;
            else next_count = next_count + 1'b1;
            for (int i = 0; i + 1 < fill; i++) begin
               held_surface[i] = held_surface[i+1];
               held_count[i] = held_count[i+1];
               held_time[i] = held_time[i+1];
            end
            fill--;
         end
         if (k > 0) begin
            w = shown_q.pop_back();
            w.last = 1'b1;
            shown_q.push_back(w);
         end
      endfunction

      function void check_word(logic [SURF_W-1:0] s, logic [TIME_W-1:0] t,
                               logic st, logic l);
         shown_word_type w;
         if (shown_q.size() == 0) begin
            $display("%0t unexpected word: surface %h time %h", $time, s, t);
            errors++;
            return;
         end
         w = shown_q.pop_front();
         if (s !== w.surface) begin
            $display("%0t surface: expected %h actual %h", $time, w.surface, s);
            errors++;
         end
         if (t !== w.show_time) begin
            $display("%0t show_time: expected %h actual %h", $time, w.show_time, t);
            errors++;
         end
         if (st !== w.status) begin
            $display("%0t status: expected %h actual %h", $time, w.status, st);
            errors++;
         end
         if (l !== w.last) begin
            $display("%0t last: expected %h actual %h", $time, w.last, l);
            errors++;
         end
      endfunction

      function int pending();
         return shown_q.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [SURF_W-1:0]       req_surface_id = '0;
   logic signed [RAW_W-1:0] req_order_count = '0;
   logic [TIME_W-1:0]       req_now_time = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [SURF_W-1:0]       rsp_out_surface;
   logic [TIME_W-1:0]       rsp_show_time;
   logic                    rsp_status;
   logic                    rsp_last;
   logic                    csr_write_enable = 1'b0;
   logic [PERIOD_W-1:0]     csr_write_data = '0;

   reorder_board board = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int frames_sent = 0;
   int cycle_count = 0;
   bit hold_req = 0;
   int hold_left = 0;

   frame_presentation_reorder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_surface_id(req_surface_id), .req_order_count(req_order_count),
      .req_now_time(req_now_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_surface(rsp_out_surface), .rsp_show_time(rsp_show_time),
      .rsp_status(rsp_status), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_out_surface, rsp_show_time, rsp_status, rsp_last);
      if (hold_req) begin
         hold_left = 500;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_frame(logic [SURF_W-1:0] surf, logic [RAW_W-1:0] raw,
                             logic [TIME_W-1:0] now);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_surface_id <= surf;
      req_order_count <= raw;
      req_now_time <= now;
      do @(posedge clock); while (req_stall);
      board.note_frame(surf, raw, now);
      frames_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(logic [PERIOD_W-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.period = value;
   endtask

   function automatic logic [RAW_W-1:0] raw_of(int cnt);
      return RAW_W'(2 * cnt + $urandom_range(1));
   endfunction

   task automatic run_sequence(int len, bit shuffle);
      int order[$];
      int tmp;
      send_frame(16'($urandom), RAW_W'($urandom_range(2) == 0 ? -1 : $urandom_range(1)),
                 {$urandom, $urandom});
      for (int i = 1; i <= len; i++) order.push_back(i);
      if (shuffle)
         for (int i = 0; i + 1 < len; i++)
            if ($urandom_range(1)) begin
               tmp = order[i];
               order[i] = order[i+1];
               order[i+1] = tmp;
            end
      foreach (order[i]) send_frame(16'($urandom), raw_of(order[i]), {$urandom, $urandom});
   endtask

   initial begin
      int negs;
      bit held_off;
      logic [PERIOD_W-1:0] p;
      negs = 0;
      held_off = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // period still zero from reset, first sequence timed at now
      send_frame(16'h0000, 17'd0, 64'd0);
      send_frame(16'hFFFF, 17'd1, {24'd0, $urandom, 8'($urandom)});

      // release burst of a full store depth
      write_period(30'd1000);
      send_frame(16'h1234, 17'd0, 64'd0);
      for (int c = 2; c <= 16; c++) send_frame(16'(c), RAW_W'(2 * c), {$urandom, $urandom});
      send_frame(16'hABCD, 17'd2, 64'd0);

      // truncation toward zero, odd raw counts
      send_frame(16'h0001, 17'h1FFFF, 64'd0);
      send_frame(16'h0002, 17'd5, 64'd0);
      send_frame(16'h0003, 17'd3, 64'd0);

      write_period({PERIOD_W{1'b1}});
      send_frame(16'h0004, 17'd0, 64'd0);
      send_frame(16'h0005, 17'd2, 64'd0);
      send_frame(16'hFFFF, 17'h10000, 64'hFFFF_FFFF_FFFF_FFFF);
      negs = 1;

      while (frames_sent < 190) begin
         case (frames_sent * 4 / 190)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 84; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 84; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(5))
               0: p = '0;
               1: p = {PERIOD_W{1'b1}};
               2: p = 30'd1000000000;
               default: p = PERIOD_W'($urandom_range(1, 1000));
            endcase
            write_period(p);
         end
         if (!held_off && frames_sent > 60) begin
            held_off = 1;
            hold_req = 1;
            idle_pct = 0;
         end
         run_sequence($urandom_range(1, 12), board.period != 0);
         if (negs < 3 && $urandom_range(15) == 0) begin
            send_frame(16'($urandom), RAW_W'(-$urandom_range(2, 65536)),
                       {2'b11, 30'($urandom), $urandom});
            negs++;
         end
      end

      // last phase fills the store for good and ends in dropped frames
      wait_drained();
      idle_pct = 12;
      stall_pct = 12;
      repeat (24) send_frame(16'($urandom), RAW_W'($urandom), {$urandom, $urandom});

      wait_drained();
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
